// ----- src/ypfc_pkg.sv -----
package ypfc_pkg;

  localparam int VEC_FRAC     = 14;
  localparam int ANG_FRAC     = 16;
  localparam int TRIG_FRAC    = 30;
  localparam int CORDIC_STEPS = 30;

  localparam logic [31:0] CORDIC_GAIN = 32'd652032874;
  localparam logic [24:0] FULL_TURN   = 25'(360 << ANG_FRAC);
  localparam logic [23:0] PITCH_LIM   = 24'(89 << ANG_FRAC);

  // division by 45 through reciprocal multiplication
  localparam logic [31:0] DEG_DIV       = 32'd45;
  localparam logic [31:0] RECIP_45_HI   = 32'd47721859;  // ceil(2^31/45), exact below 2^25
  localparam logic [31:0] RECIP_45_LO   = 32'd745655;    // ceil(2^25/45), exact below 2^19

  // register indexes
  localparam logic [2:0] CFG_START_X     = 3'd0;
  localparam logic [2:0] CFG_START_Y     = 3'd1;
  localparam logic [2:0] CFG_START_Z     = 3'd2;
  localparam logic [2:0] CFG_START_YAW   = 3'd3;
  localparam logic [2:0] CFG_START_PITCH = 3'd4;
  localparam logic [2:0] CFG_LOOK_GAIN   = 3'd5;

  localparam logic ACT_LOOK = 1'b0;
  localparam logic ACT_MOVE = 1'b1;

  typedef struct packed {
    logic               action;
    logic signed [15:0] mouse_dx;
    logic signed [15:0] mouse_dy;
    logic signed [15:0] forward_speed;
    logic signed [15:0] strafe_speed;
    logic        [15:0] time_step;
  } ypfc_in_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] front_x;
    logic signed [15:0] front_y;
    logic signed [15:0] front_z;
    logic signed [15:0] right_x;
    logic signed [15:0] right_y;
    logic signed [15:0] right_z;
    logic signed [15:0] up_x;
    logic signed [15:0] up_y;
    logic signed [15:0] up_z;
  } ypfc_out_t;

  typedef enum logic [4:0] {
    ST_INIT, ST_IDLE,
    ST_LK_A, ST_LK_B, ST_LK_C, ST_MOD,
    ST_MV_A, ST_MV_B, ST_MV_C, ST_MV_D,
    ST_V_LOAD, ST_V_DIV, ST_V_PREP, ST_V_ROT, ST_V_POST, ST_V_MUL, ST_V_RND,
    ST_DONE
  } ypfc_state_t;

  // atan(2^-i) in turns scaled by 2^32
  function automatic logic [29:0] arc_value(input logic [4:0] i);
    logic [29:0] a;
    case (i)
      5'd0:  a = 30'd536870912;
      5'd1:  a = 30'd316933406;
      5'd2:  a = 30'd167458907;
      5'd3:  a = 30'd85004756;
      5'd4:  a = 30'd42667331;
      5'd5:  a = 30'd21354465;
      5'd6:  a = 30'd10679838;
      5'd7:  a = 30'd5340245;
      5'd8:  a = 30'd2670163;
      5'd9:  a = 30'd1335087;
      5'd10: a = 30'd667544;
      5'd11: a = 30'd333772;
      5'd12: a = 30'd166886;
      5'd13: a = 30'd83443;
      5'd14: a = 30'd41722;
      5'd15: a = 30'd20861;
      5'd16: a = 30'd10430;
      5'd17: a = 30'd5215;
      5'd18: a = 30'd2608;
      5'd19: a = 30'd1304;
      5'd20: a = 30'd652;
      5'd21: a = 30'd326;
      5'd22: a = 30'd163;
      5'd23: a = 30'd81;
      5'd24: a = 30'd41;
      5'd25: a = 30'd20;
      5'd26: a = 30'd10;
      5'd27: a = 30'd5;
      5'd28: a = 30'd3;
      5'd29: a = 30'd1;
      default: a = 30'd0;
    endcase
    return a;
  endfunction

endpackage

// ----- src/yaw_pitch_fly_camera.sv -----
// channel  ports                          width      handshake
// in       in_valid/in_ready/in_data      81 bits    valid/ready
// out      out_valid/out_ready/out_data   240 bits   valid/ready
// cfg      cfg_we/cfg_index/cfg_data      3+32 bits  write enable, no wait
//
// a move word runs its three axes through the shared multiplier,
// a look word is dominated by two binary-angle conversions (reciprocal multiply by 1/45)
// and two 30-step cordic runs, all on one shared unit
// reset and every register write rebuild the pose (in_ready low)
// the result sits in an output register, so a stalled out side holds one word
// while the next in word is already being worked on
module yaw_pitch_fly_camera (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ypfc_pkg::ypfc_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ypfc_pkg::ypfc_out_t out_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data
);
  import ypfc_pkg::*;

  // round to nearest, ties away from zero
  function automatic logic signed [63:0] rnd_sh(input logic signed [63:0] v,
                                                input logic [5:0] s);
    logic [63:0] mag;
    mag = v[63] ? 64'(-v) : 64'(v);
    mag = (mag + (64'd1 << (s - 6'd1))) >> s;
    return v[63] ? -$signed(mag) : $signed(mag);
  endfunction

  localparam logic signed [34:0] FULL35 = 35'(FULL_TURN);
  localparam logic signed [34:0] LIM35  = 35'(PITCH_LIM);
  localparam logic signed [32:0] ONE33  = 33'sd1 <<< TRIG_FRAC;

  ypfc_state_t state_r, state_nxt;

  // configuration
  logic signed [31:0] start_x_r, start_y_r, start_z_r;
  logic        [24:0] start_yaw_r;
  logic signed [23:0] start_pitch_r;
  logic        [15:0] look_gain_r;

  // pose
  logic signed [31:0] pos_r   [3];
  logic signed [31:0] pos_nxt [3];
  logic signed [15:0] front_r [3];
  logic signed [15:0] front_nxt [3];
  logic signed [15:0] right_r [3];
  logic signed [15:0] right_nxt [3];
  logic signed [15:0] up_r    [3];
  logic signed [15:0] up_nxt  [3];
  logic        [24:0] yaw_r, yaw_nxt;
  logic signed [23:0] pitch_r, pitch_nxt;

  // working registers
  logic signed [31:0] cy_r, cy_nxt, sy_r, sy_nxt, cp_r, cp_nxt, sp_r, sp_nxt;
  logic signed [63:0] prod_r, prod_nxt;
  logic signed [31:0] acc_r, acc_nxt;
  logic signed [34:0] modv_r, modv_nxt;
  logic        [24:0] mag_r, mag_nxt;
  logic        [5:0]  rem_r, rem_nxt;
  logic        [31:0] dq_r, dq_nxt;
  logic signed [32:0] x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  logic               flip_r, flip_nxt, neg_r, neg_nxt, sel_r, sel_nxt;
  logic               cfg_run_r, cfg_run_nxt;
  logic        [4:0]  cnt_r, cnt_nxt;
  ypfc_in_t           in_r, in_nxt;
  ypfc_out_t          out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;

  // shared multiplier
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_p;
  assign mul_p = mul_a * mul_b;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_INIT;
      out_valid_r   <= 1'b0;
      cfg_run_r     <= 1'b1;
      cnt_r         <= '0;
      sel_r         <= 1'b0;
      start_x_r     <= '0;
      start_y_r     <= '0;
      start_z_r     <= '0;
      start_yaw_r   <= '0;
      start_pitch_r <= '0;
      look_gain_r   <= 16'd6554;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cfg_run_r   <= cfg_run_nxt;
      cnt_r       <= cnt_nxt;
      sel_r       <= sel_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_START_X:     start_x_r     <= cfg_data;
          CFG_START_Y:     start_y_r     <= cfg_data;
          CFG_START_Z:     start_z_r     <= cfg_data;
          CFG_START_YAW:   start_yaw_r   <= cfg_data[24:0];
          CFG_START_PITCH: start_pitch_r <= cfg_data[23:0];
          CFG_LOOK_GAIN:   look_gain_r   <= cfg_data[15:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    pos_r   <= pos_nxt;
    front_r <= front_nxt;
    right_r <= right_nxt;
    up_r    <= up_nxt;
    yaw_r   <= yaw_nxt;
    pitch_r <= pitch_nxt;
    cy_r    <= cy_nxt;
    sy_r    <= sy_nxt;
    cp_r    <= cp_nxt;
    sp_r    <= sp_nxt;
    prod_r  <= prod_nxt;
    acc_r   <= acc_nxt;
    modv_r  <= modv_nxt;
    mag_r   <= mag_nxt;
    rem_r   <= rem_nxt;
    dq_r    <= dq_nxt;
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    z_r     <= z_nxt;
    flip_r  <= flip_nxt;
    neg_r   <= neg_nxt;
    in_r    <= in_nxt;
    out_r   <= out_nxt;
  end

  always_comb begin
    logic signed [34:0] ysum, psum, mlim, mv2;
    logic signed [25:0] deg;
    logic        [24:0] mag;
    logic               fl;
    logic        [31:0] t, tt;
    logic signed [32:0] xs, ys, cx, cs;
    logic signed [31:0] cc, ss;
    logic signed [63:0] rv, psat;
    logic        [1:0]  ax;

    state_nxt     = state_r;
    pos_nxt       = pos_r;
    front_nxt     = front_r;
    right_nxt     = right_r;
    up_nxt        = up_r;
    yaw_nxt       = yaw_r;
    pitch_nxt     = pitch_r;
    cy_nxt        = cy_r;
    sy_nxt        = sy_r;
    cp_nxt        = cp_r;
    sp_nxt        = sp_r;
    prod_nxt      = prod_r;
    acc_nxt       = acc_r;
    modv_nxt      = modv_r;
    mag_nxt       = mag_r;
    rem_nxt       = rem_r;
    dq_nxt        = dq_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    z_nxt         = z_r;
    flip_nxt      = flip_r;
    neg_nxt       = neg_r;
    sel_nxt       = sel_r;
    cfg_run_nxt   = cfg_run_r;
    cnt_nxt       = cnt_r;
    in_nxt        = in_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    mul_a         = '0;
    mul_b         = '0;
    ysum = '0; psum = '0; mlim = '0; mv2 = '0;
    deg = '0; mag = '0; fl = 1'b0;
    t = '0; tt = '0; xs = '0; ys = '0; cx = '0; cs = '0; cc = '0; ss = '0;
    rv = '0; psat = '0;
    ax = cnt_r[1:0];

    unique case (state_r)
      ST_INIT: begin
        pos_nxt[0]  = start_x_r;
        pos_nxt[1]  = start_y_r;
        pos_nxt[2]  = start_z_r;
        yaw_nxt     = (start_yaw_r >= FULL_TURN) ? start_yaw_r - FULL_TURN : start_yaw_r;
        if (start_pitch_r > $signed(PITCH_LIM))       pitch_nxt = PITCH_LIM;
        else if (start_pitch_r < -$signed(PITCH_LIM)) pitch_nxt = -$signed(PITCH_LIM);
        else                                          pitch_nxt = start_pitch_r;
        cfg_run_nxt = 1'b1;
        sel_nxt     = 1'b0;
        state_nxt   = ST_V_LOAD;
      end
      ST_IDLE: begin
        if (in_valid) begin
          in_nxt      = in_data;
          cfg_run_nxt = 1'b0;
          cnt_nxt     = '0;
          state_nxt   = (in_data.action == ACT_MOVE) ? ST_MV_A : ST_LK_A;
        end
      end
      // look: scale deltas, wrap yaw, clamp pitch
      ST_LK_A: begin
        mul_a     = 32'(in_r.mouse_dx);
        mul_b     = $signed({16'd0, look_gain_r});
        prod_nxt  = mul_p;
        state_nxt = ST_LK_B;
      end
      ST_LK_B: begin
        ysum = $signed({10'd0, yaw_r}) + prod_r[34:0];
        // a whole number of turns keeps the remainder and makes it positive
        modv_nxt  = ysum[34] ? ysum + (FULL35 <<< 7) : ysum;
        mul_a     = 32'(in_r.mouse_dy);
        mul_b     = $signed({16'd0, look_gain_r});
        prod_nxt  = mul_p;
        state_nxt = ST_LK_C;
      end
      ST_LK_C: begin
        psum = 35'(pitch_r) - prod_r[34:0];
        if (psum > LIM35)       pitch_nxt = PITCH_LIM;
        else if (psum < -LIM35) pitch_nxt = -$signed(PITCH_LIM);
        else                    pitch_nxt = psum[23:0];
        cnt_nxt   = 5'd7;
        state_nxt = ST_MOD;
      end
      ST_MOD: begin
        mlim = FULL35 <<< cnt_r[2:0];
        mv2  = (modv_r >= mlim) ? modv_r - mlim : modv_r;
        modv_nxt = mv2;
        if (cnt_r == 5'd0) begin
          yaw_nxt   = mv2[24:0];
          sel_nxt   = 1'b0;
          state_nxt = ST_V_LOAD;
        end else begin
          cnt_nxt = cnt_r - 5'd1;
        end
      end
      // move: per axis (f*fs + r*ss)*dt
      ST_MV_A: begin
        mul_a     = 32'(front_r[ax]);
        mul_b     = 32'(in_r.forward_speed);
        prod_nxt  = mul_p;
        state_nxt = ST_MV_B;
      end
      ST_MV_B: begin
        acc_nxt   = prod_r[31:0];
        mul_a     = 32'(right_r[ax]);
        mul_b     = 32'(in_r.strafe_speed);
        prod_nxt  = mul_p;
        state_nxt = ST_MV_C;
      end
      ST_MV_C: begin
        mul_a     = acc_r + prod_r[31:0];
        mul_b     = $signed({16'd0, in_r.time_step});
        prod_nxt  = mul_p;
        state_nxt = ST_MV_D;
      end
      ST_MV_D: begin
        rv   = rnd_sh(prod_r, 6'(VEC_FRAC + 8));
        psat = 64'(pos_r[ax]) + rv;
        if (psat > 64'sd2147483647)       pos_nxt[ax] = 32'sh7fffffff;
        else if (psat < -64'sd2147483648) pos_nxt[ax] = 32'sh80000000;
        else                              pos_nxt[ax] = psat[31:0];
        if (cnt_r == 5'd2) begin
          state_nxt = ST_DONE;
        end else begin
          cnt_nxt   = cnt_r + 5'd1;
          state_nxt = ST_MV_A;
        end
      end
      // degrees to binary angle: (|deg|*2^16 + 180) / 360 = (|deg|*8192 + 22) / 45,
      // with |deg| = 45*a + b the quotient is a*8192 + (b*8192 + 22) / 45
      ST_V_LOAD: begin
        deg     = sel_r ? 26'(pitch_r) : $signed({1'b0, yaw_r});
        neg_nxt = deg[25];
        mag     = deg[25] ? 25'(-deg) : deg[24:0];
        mag_nxt = mag;
        cnt_nxt = '0;
        state_nxt = ST_V_DIV;
      end
      ST_V_DIV: begin
        case (cnt_r)
          5'd0: begin
            mul_a    = $signed({7'd0, mag_r});
            mul_b    = RECIP_45_HI;
            prod_nxt = mul_p;
          end
          5'd1: begin
            // a = |deg| / 45, then a*45 for the remainder
            dq_nxt   = {prod_r[49:31], 13'd0};
            mul_a    = $signed({13'd0, prod_r[49:31]});
            mul_b    = DEG_DIV;
            prod_nxt = mul_p;
          end
          5'd2: rem_nxt = 6'(mag_r - prod_r[24:0]);
          5'd3: begin
            // b*8192 plus the rounding offset 180/8
            mul_a    = $signed({13'd0, rem_r, 13'd22});
            mul_b    = RECIP_45_LO;
            prod_nxt = mul_p;
          end
          default: begin
            dq_nxt    = {dq_r[31:13], prod_r[37:25]};
            state_nxt = ST_V_PREP;
          end
        endcase
        cnt_nxt = cnt_r + 5'd1;
      end
      ST_V_PREP: begin
        t  = neg_r ? -dq_r : dq_r;
        // second and third quadrant: turn by half and negate afterwards
        fl = (t[31:30] == 2'b01) || (t[31:30] == 2'b10);
        tt = fl ? t - 32'h80000000 : t;
        flip_nxt  = fl;
        z_nxt     = 33'($signed(tt));
        x_nxt     = $signed({1'b0, CORDIC_GAIN});
        y_nxt     = '0;
        cnt_nxt   = '0;
        state_nxt = ST_V_ROT;
      end
      ST_V_ROT: begin
        xs = x_r >>> cnt_r;
        ys = y_r >>> cnt_r;
        if (!z_r[32]) begin
          x_nxt = x_r - ys;
          y_nxt = y_r + xs;
          z_nxt = z_r - $signed({3'd0, arc_value(cnt_r)});
        end else begin
          x_nxt = x_r + ys;
          y_nxt = y_r - xs;
          z_nxt = z_r + $signed({3'd0, arc_value(cnt_r)});
        end
        if (cnt_r == 5'(CORDIC_STEPS - 1)) state_nxt = ST_V_POST;
        cnt_nxt = cnt_r + 5'd1;
      end
      ST_V_POST: begin
        cx = flip_r ? -x_r : x_r;
        cs = flip_r ? -y_r : y_r;
        if (cx > ONE33)       cc = 32'(ONE33);
        else if (cx < -ONE33) cc = 32'(-ONE33);
        else                  cc = cx[31:0];
        if (cs > ONE33)       ss = 32'(ONE33);
        else if (cs < -ONE33) ss = 32'(-ONE33);
        else                  ss = cs[31:0];
        if (!sel_r) begin
          cy_nxt    = cc;
          sy_nxt    = ss;
          sel_nxt   = 1'b1;
          state_nxt = ST_V_LOAD;
        end else begin
          cp_nxt       = cc;
          sp_nxt       = ss;
          front_nxt[1] = 16'(rnd_sh(64'(ss), 6'(TRIG_FRAC - VEC_FRAC)));
          right_nxt[0] = 16'(-rnd_sh(64'(sy_r), 6'(TRIG_FRAC - VEC_FRAC)));
          right_nxt[1] = '0;
          right_nxt[2] = 16'(rnd_sh(64'(cy_r), 6'(TRIG_FRAC - VEC_FRAC)));
          up_nxt[1]    = 16'(rnd_sh(64'(cc), 6'(TRIG_FRAC - VEC_FRAC)));
          cnt_nxt      = '0;
          state_nxt    = ST_V_MUL;
        end
      end
      // products cy*cp, sy*cp, cy*sp, sy*sp
      ST_V_MUL: begin
        mul_a     = cnt_r[0] ? sy_r : cy_r;
        mul_b     = cnt_r[1] ? sp_r : cp_r;
        prod_nxt  = mul_p;
        state_nxt = ST_V_RND;
      end
      ST_V_RND: begin
        rv = rnd_sh(prod_r, 6'(2 * TRIG_FRAC - VEC_FRAC));
        case (cnt_r[1:0])
          2'd0:    front_nxt[0] = 16'(rv);
          2'd1:    front_nxt[2] = 16'(rv);
          2'd2:    up_nxt[0]    = 16'(-rv);
          default: up_nxt[2]    = 16'(-rv);
        endcase
        if (cnt_r == 5'd3) begin
          state_nxt = cfg_run_r ? ST_IDLE : ST_DONE;
        end else begin
          cnt_nxt   = cnt_r + 5'd1;
          state_nxt = ST_V_MUL;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_nxt.pos_x   = pos_r[0];
          out_nxt.pos_y   = pos_r[1];
          out_nxt.pos_z   = pos_r[2];
          out_nxt.front_x = front_r[0];
          out_nxt.front_y = front_r[1];
          out_nxt.front_z = front_r[2];
          out_nxt.right_x = right_r[0];
          out_nxt.right_y = right_r[1];
          out_nxt.right_z = right_r[2];
          out_nxt.up_x    = up_r[0];
          out_nxt.up_y    = up_r[1];
          out_nxt.up_z    = up_r[2];
          out_valid_nxt   = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      default: state_nxt = ST_INIT;
    endcase

    // any register write rebuilds the pose
    if (cfg_we && (cfg_index <= CFG_LOOK_GAIN)) state_nxt = ST_INIT;
  end

endmodule
